[rtl/hpp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpp_pkg
// Shared types and constants for the helix propagation block.
// ----------------------------------------------------------------------------
package hpp_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int TAB_LEN       = 24;
	localparam int CIDX_W        = 5;

	localparam int CW    = 43;
	localparam int ZW    = 34;
	localparam int CSW   = 27;
	localparam int AW    = 38;
	localparam int BW    = 27;
	localparam int PW    = 65;
	localparam int ACCW  = 66;
	localparam int DVD_W = 58;
	localparam int DVS_W = 32;
	localparam int NW    = 15;

	localparam logic [30:0] ATAN_TURNS [TAB_LEN] = '{
		31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756, 31'd42667333,
		31'd21354465, 31'd10679838, 31'd5340245, 31'd2670163, 31'd1335087,
		31'd667544, 31'd333772, 31'd166886, 31'd83443, 31'd41722, 31'd20861,
		31'd10430, 31'd5215, 31'd2608, 31'd1304, 31'd652, 31'd326, 31'd163, 31'd81
	};

	localparam logic signed [CW-1:0] GAIN_Q24     = 43'sd10188014;
	localparam logic signed [ZW-1:0] HALF_TURN    = 34'sd2147483648;
	localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [27:0]   ONE_Q24      = 28'sd16777216;
	localparam logic [19:0]          MASS_SQ      = 20'd749206;
	localparam logic [21:0]          TURN_COEF    = 22'd2459112;
	localparam logic [31:0]          RAD_COEF     = 32'd3373259426;
	localparam logic [14:0]          RADIUS_NUM   = 15'd32000;
	localparam logic [36:0]          RADIUS_CAP   = 37'd68719476736;
	localparam logic signed [42:0]   POS_CAP      = 43'sd4194304;
	localparam logic [63:0]          RND_HALF     = 64'h0000_8000_0000_0000;

	localparam logic [11:0] FS_RST  = 12'd973;
	localparam logic [15:0] TS_RST  = 16'd102;
	localparam logic [13:0] LIM_RST = 14'd10000;

	typedef enum logic [1:0] {
		REG_FIELD = 2'd0,
		REG_TSTEP = 2'd1,
		REG_LIMIT = 2'd2
	} reg_idx_t;

	typedef enum logic [4:0] {
		MOP_PXPX, MOP_PYPY, MOP_PZPZ, MOP_TXTX, MOP_TYTY, MOP_TSFS, MOP_NUM,
		MOP_APX, MOP_APY, MOP_RYC, MOP_RXS, MOP_RXC, MOP_RYS, MOP_XX, MOP_YY,
		MOP_PLO, MOP_PHI
	} mop_t;

	typedef enum logic [1:0] {
		AOP_NONE, AOP_LOAD, AOP_ADD, AOP_ADD16
	} aop_t;

	typedef enum logic [2:0] {
		ST_NONE, ST_TGT, ST_S8, ST_RX, ST_RY, ST_X, ST_Y
	} st_t;

	typedef struct packed {
		logic load;
		mop_t mop;
		aop_t aop;
		logic sq_go;
		logic div_go;
		logic div_rad;
		logic cor_go;
		logic cor_vec;
		st_t  st;
		logic adv;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic sq_busy;
		logic div_busy;
		logic cor_busy;
		logic outside;
		logic limit_next;
	} sts_t;

endpackage

[rtl/hpp_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpp_cordic
// Iterative CORDIC, one micro-rotation per cycle; rotation (sin/cos) or
// vectoring (atan2) mode.
// ----------------------------------------------------------------------------
module hpp_cordic (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               vec,
	input  logic [31:0]                        ang,
	input  logic signed [23:0]                 vx,
	input  logic signed [23:0]                 vy,
	output logic                               busy,
	output logic signed [hpp_pkg::CSW-1:0]     cos_o,
	output logic signed [hpp_pkg::CSW-1:0]     sin_o,
	output logic [31:0]                        dir
);

	logic signed [hpp_pkg::CW-1:0] x_q, y_q, x0, y0, dx, dy, xv, yv;
	logic signed [hpp_pkg::ZW-1:0] z_q, z0, zr, at;
	logic [hpp_pkg::CIDX_W-1:0]    i_q;
	logic                          busy_q, neg_q, vec_q, neg0, sub;

	always_comb begin
		zr = $signed({{2{ang[31]}}, ang});
		xv = $signed({{3{vx[23]}}, vx, 16'd0});
		yv = $signed({{3{vy[23]}}, vy, 16'd0});
		neg0 = 1'b0;
		if (vec) begin
			if (xv < 0) begin
				x0 = -xv;
				y0 = -yv;
				z0 = hpp_pkg::HALF_TURN;
			end else begin
				x0 = xv;
				y0 = yv;
				z0 = '0;
			end
		end else begin
			x0 = hpp_pkg::GAIN_Q24;
			y0 = '0;
			z0 = zr;
			if (zr > hpp_pkg::QUARTER_TURN) begin
				z0 = zr - hpp_pkg::HALF_TURN;
				neg0 = 1'b1;
			end else if (zr < -hpp_pkg::QUARTER_TURN) begin
				z0 = zr + hpp_pkg::HALF_TURN;
				neg0 = 1'b1;
			end
		end
	end

	assign dx  = y_q >>> i_q;
	assign dy  = x_q >>> i_q;
	assign at  = $signed({3'd0, hpp_pkg::ATAN_TURNS[i_q]});
	assign sub = vec_q ? y_q[hpp_pkg::CW-1] : ~z_q[hpp_pkg::ZW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q    <= '0;
		end else if (busy_q) begin
			if (i_q == hpp_pkg::CIDX_W'(hpp_pkg::CORDIC_STAGES - 1)) begin
				busy_q <= 1'b0;
			end
			i_q <= i_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x0;
			y_q   <= y0;
			z_q   <= z0;
			neg_q <= neg0;
			vec_q <= vec;
		end else if (busy_q) begin
			if (sub) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign busy  = busy_q;
	assign cos_o = neg_q ? -x_q[hpp_pkg::CSW-1:0] : x_q[hpp_pkg::CSW-1:0];
	assign sin_o = neg_q ? -y_q[hpp_pkg::CSW-1:0] : y_q[hpp_pkg::CSW-1:0];
	assign dir   = z_q[31:0];

endmodule

[rtl/hpp_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpp_dp
// Datapath: config registers, shared multiplier and accumulator, square root,
// divider, CORDIC, helix position and result registers.
// ----------------------------------------------------------------------------
module hpp_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hpp_pkg::cmd_t         cmd,
	output hpp_pkg::sts_t         sts,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_idx,
	input  logic [15:0]           cfg_data,
	input  logic signed [19:0]    ref_x,
	input  logic signed [19:0]    ref_y,
	input  logic signed [23:0]    mom_x,
	input  logic signed [23:0]    mom_y,
	input  logic signed [23:0]    mom_z,
	input  logic                  charge_negative,
	input  logic signed [19:0]    target_x,
	input  logic signed [19:0]    target_y,
	output logic signed [15:0]    phi,
	output logic                  limit_hit
);

	function automatic logic signed [23:0] pos_clamp(input logic signed [42:0] v);
		logic signed [42:0] r;
		if (v > hpp_pkg::POS_CAP) r = hpp_pkg::POS_CAP;
		else if (v < -hpp_pkg::POS_CAP) r = -hpp_pkg::POS_CAP;
		else r = v;
		return r[23:0];
	endfunction

	logic [11:0] fs_q, fs;
	logic [15:0] ts_q;
	logic [13:0] lim_q;
	logic [13:0] d3;

	logic signed [19:0] rx_q, ry_q, tx_q, ty_q;
	logic signed [23:0] px_q, py_q, pz_q;
	logic               negq_q;
	logic [23:0]        apx, apy;

	logic signed [hpp_pkg::AW-1:0]   a;
	logic signed [hpp_pkg::BW-1:0]   b;
	logic signed [hpp_pkg::PW-1:0]   p_s1;
	hpp_pkg::aop_t                   aop_s1;
	logic signed [hpp_pkg::ACCW-1:0] acc_q, acc_sh;

	logic [63:0] sq_v_q, sq_r_q, sq_bit, sq_sum;
	logic [6:0]  sq_sh;
	logic [4:0]  sq_cnt_q;
	logic        sq_busy_q;
	logic [31:0] e20;

	logic [hpp_pkg::DVD_W-1:0] dv_q;
	logic [hpp_pkg::DVS_W-1:0] rem_q, dv_d_q;
	logic [hpp_pkg::DVS_W:0]   dv_t;
	logic                      dv_ge;
	logic [5:0]                dv_cnt_q;
	logic                      div_busy_q;

	logic [40:0]              tgt_q;
	logic [39:0]              s8_q, tacc_q;
	logic signed [37:0]       radx_q, rady_q, rmag;
	logic [36:0]              qmag;
	logic signed [23:0]       x_q, y_q;
	logic signed [42:0]       pos_w;
	logic [hpp_pkg::NW-1:0]   n_q, n_nx;
	logic                     limit_q, lim_out_q;
	logic signed [15:0]       phi_q;

	logic [31:0] turn, ang, phase, ph_abs;
	logic [63:0] rnd;
	logic [15:0] mag16;

	logic                             cor_busy;
	logic signed [hpp_pkg::CSW-1:0]   cosv, sinv;
	logic [31:0]                      cdir;
	logic signed [27:0]               omc, cm1;

	assign fs  = (fs_q == 12'd0) ? 12'd1 : fs_q;
	assign d3  = {1'b0, fs, 1'b0} + {2'b00, fs};
	assign apx = px_q[23] ? 24'(-px_q) : 24'(px_q);
	assign apy = py_q[23] ? 24'(-py_q) : 24'(py_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q  <= hpp_pkg::FS_RST;
			ts_q  <= hpp_pkg::TS_RST;
			lim_q <= hpp_pkg::LIM_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				hpp_pkg::REG_FIELD: fs_q  <= cfg_data[11:0];
				hpp_pkg::REG_TSTEP: ts_q  <= cfg_data;
				hpp_pkg::REG_LIMIT: lim_q <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	hpp_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.cor_go),
		.vec    (cmd.cor_vec),
		.ang    (ang),
		.vx     (px_q),
		.vy     (py_q),
		.busy   (cor_busy),
		.cos_o  (cosv),
		.sin_o  (sinv),
		.dir    (cdir)
	);

	assign omc    = hpp_pkg::ONE_Q24 - 28'(cosv);
	assign cm1    = 28'(cosv) - hpp_pkg::ONE_Q24;
	assign turn   = tacc_q[39:8];
	assign ang    = negq_q ? -turn : turn;
	assign phase  = cdir - ang;
	assign ph_abs = phase[31] ? -phase : phase;

	always_comb begin
		a = '0;
		b = '0;
		case (cmd.mop)
			hpp_pkg::MOP_PXPX: begin a = hpp_pkg::AW'(px_q); b = hpp_pkg::BW'(px_q); end
			hpp_pkg::MOP_PYPY: begin a = hpp_pkg::AW'(py_q); b = hpp_pkg::BW'(py_q); end
			hpp_pkg::MOP_PZPZ: begin a = hpp_pkg::AW'(pz_q); b = hpp_pkg::BW'(pz_q); end
			hpp_pkg::MOP_TXTX: begin a = hpp_pkg::AW'(tx_q); b = hpp_pkg::BW'(tx_q); end
			hpp_pkg::MOP_TYTY: begin a = hpp_pkg::AW'(ty_q); b = hpp_pkg::BW'(ty_q); end
			hpp_pkg::MOP_TSFS: begin a = hpp_pkg::AW'(ts_q); b = hpp_pkg::BW'(fs); end
			hpp_pkg::MOP_NUM: begin
				a = hpp_pkg::AW'(acc_q[27:0]);
				b = hpp_pkg::BW'(hpp_pkg::TURN_COEF);
			end
			hpp_pkg::MOP_APX: begin a = hpp_pkg::AW'(apx); b = hpp_pkg::BW'(hpp_pkg::RADIUS_NUM); end
			hpp_pkg::MOP_APY: begin a = hpp_pkg::AW'(apy); b = hpp_pkg::BW'(hpp_pkg::RADIUS_NUM); end
			hpp_pkg::MOP_RYC: begin a = rady_q; b = hpp_pkg::BW'(omc); end
			hpp_pkg::MOP_RXS: begin a = radx_q; b = sinv; end
			hpp_pkg::MOP_RXC: begin a = radx_q; b = hpp_pkg::BW'(cm1); end
			hpp_pkg::MOP_RYS: begin a = rady_q; b = sinv; end
			hpp_pkg::MOP_XX:  begin a = hpp_pkg::AW'(x_q); b = hpp_pkg::BW'(x_q); end
			hpp_pkg::MOP_YY:  begin a = hpp_pkg::AW'(y_q); b = hpp_pkg::BW'(y_q); end
			hpp_pkg::MOP_PLO: begin
				a = hpp_pkg::AW'(ph_abs);
				b = hpp_pkg::BW'(hpp_pkg::RAD_COEF[15:0]);
			end
			hpp_pkg::MOP_PHI: begin
				a = hpp_pkg::AW'(ph_abs);
				b = hpp_pkg::BW'(hpp_pkg::RAD_COEF[31:16]);
			end
			default: ;
		endcase
	end

	// square root, one result bit per cycle
	assign sq_sh  = 7'd62 - {1'b0, sq_cnt_q, 1'b0};
	assign sq_bit = 64'd1 << sq_sh;
	assign sq_sum = sq_r_q + sq_bit;
	assign e20    = (sq_r_q[31:0] == 32'd0) ? 32'd1 : sq_r_q[31:0];

	// restoring divider, one quotient bit per cycle
	assign dv_t  = {rem_q, dv_q[hpp_pkg::DVD_W-1]};
	assign dv_ge = dv_t >= {1'b0, dv_d_q};

	assign n_nx   = n_q + 1'b1;
	assign acc_sh = acc_q >>> 24;
	assign pos_w  = 43'(cmd.st == hpp_pkg::ST_X ? rx_q : ry_q) + 43'(acc_sh);
	assign qmag   = (dv_q > hpp_pkg::DVD_W'(hpp_pkg::RADIUS_CAP)) ?
		hpp_pkg::RADIUS_CAP : dv_q[36:0];
	assign rmag   = 38'(qmag);
	assign rnd    = acc_q[63:0] + hpp_pkg::RND_HALF;
	assign mag16  = rnd[63:48];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aop_s1     <= hpp_pkg::AOP_NONE;
			sq_busy_q  <= 1'b0;
			sq_cnt_q   <= '0;
			div_busy_q <= 1'b0;
			dv_cnt_q   <= '0;
		end else begin
			aop_s1 <= cmd.aop;
			if (cmd.sq_go) begin
				sq_busy_q <= 1'b1;
				sq_cnt_q  <= '0;
			end else if (sq_busy_q) begin
				if (sq_cnt_q == 5'd31) sq_busy_q <= 1'b0;
				sq_cnt_q <= sq_cnt_q + 1'b1;
			end
			if (cmd.div_go) begin
				div_busy_q <= 1'b1;
				dv_cnt_q   <= '0;
			end else if (div_busy_q) begin
				if (dv_cnt_q == 6'(hpp_pkg::DVD_W - 1)) div_busy_q <= 1'b0;
				dv_cnt_q <= dv_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
		case (aop_s1)
			hpp_pkg::AOP_LOAD:  acc_q <= hpp_pkg::ACCW'(p_s1);
			hpp_pkg::AOP_ADD:   acc_q <= acc_q + hpp_pkg::ACCW'(p_s1);
			hpp_pkg::AOP_ADD16: acc_q <= acc_q + (hpp_pkg::ACCW'(p_s1) <<< 16);
			default: ;
		endcase

		if (cmd.sq_go) begin
			sq_v_q <= {2'b00, acc_q[47:0] + 48'(hpp_pkg::MASS_SQ), 14'd0};
			sq_r_q <= '0;
		end else if (sq_busy_q) begin
			if (sq_v_q >= sq_sum) begin
				sq_v_q <= sq_v_q - sq_sum;
				sq_r_q <= (sq_r_q >> 1) + sq_bit;
			end else begin
				sq_r_q <= sq_r_q >> 1;
			end
		end

		if (cmd.div_go) begin
			rem_q <= '0;
			if (cmd.div_rad) begin
				dv_q   <= hpp_pkg::DVD_W'(acc_q[38:0]) + hpp_pkg::DVD_W'(d3 >> 1);
				dv_d_q <= hpp_pkg::DVS_W'(d3);
			end else begin
				dv_q   <= {acc_q[49:0], 8'd0};
				dv_d_q <= e20;
			end
		end else if (div_busy_q) begin
			rem_q <= dv_ge ? hpp_pkg::DVS_W'(dv_t - {1'b0, dv_d_q}) : dv_t[hpp_pkg::DVS_W-1:0];
			dv_q  <= {dv_q[hpp_pkg::DVD_W-2:0], dv_ge};
		end

		if (cmd.load) begin
			rx_q   <= ref_x;
			ry_q   <= ref_y;
			px_q   <= mom_x;
			py_q   <= mom_y;
			pz_q   <= mom_z;
			negq_q <= charge_negative;
			tx_q   <= target_x;
			ty_q   <= target_y;
		end

		case (cmd.st)
			hpp_pkg::ST_TGT: tgt_q  <= acc_q[40:0];
			hpp_pkg::ST_S8:  s8_q   <= dv_q[39:0];
			hpp_pkg::ST_RX:  radx_q <= (px_q[23] ^ negq_q) ? -rmag : rmag;
			hpp_pkg::ST_RY:  rady_q <= (py_q[23] ^ negq_q) ? -rmag : rmag;
			hpp_pkg::ST_X:   x_q    <= pos_clamp(pos_w);
			hpp_pkg::ST_Y:   y_q    <= pos_clamp(pos_w);
			default: ;
		endcase

		if (cmd.out_load) begin
			lim_out_q <= limit_q;
			if (px_q == 24'sd0 && py_q == 24'sd0) phi_q <= '0;
			else phi_q <= phase[31] ? -$signed(mag16) : $signed(mag16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			tacc_q  <= '0;
			limit_q <= 1'b0;
		end else if (cmd.load) begin
			n_q     <= '0;
			tacc_q  <= '0;
			limit_q <= 1'b0;
		end else if (cmd.adv) begin
			n_q     <= n_nx;
			tacc_q  <= tacc_q + s8_q;
			limit_q <= sts.limit_next;
		end
	end

	always_comb begin
		sts.sq_busy    = sq_busy_q;
		sts.div_busy   = div_busy_q;
		sts.cor_busy   = cor_busy;
		sts.outside    = !(acc_q[46:0] < 47'(tgt_q));
		sts.limit_next = n_nx > hpp_pkg::NW'(lim_q);
	end

	assign phi       = phi_q;
	assign limit_hit = lim_out_q;

endmodule

[rtl/hpp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpp_ctrl
// Sequencer: setup arithmetic, helix step loop, final angle, output register
// handshake.
// ----------------------------------------------------------------------------
module hpp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  hpp_pkg::sts_t  sts,
	output hpp_pkg::cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE, S_PX, S_PY, S_PZ, S_W0, S_SQ, S_TX, S_TY, S_W1, S_TGT, S_TSFS,
		S_W2, S_NUM, S_W3, S_SQW, S_D8, S_D8W, S_S8, S_APX, S_WX, S_DX, S_DXW,
		S_STX, S_APY, S_WY, S_DY, S_DYW, S_STY, S_ROT, S_ROTW, S_M1, S_M2, S_WPX,
		S_STPX, S_M3, S_M4, S_WPY, S_STPY, S_M5, S_M6, S_WR, S_CHK, S_VEC, S_VECW,
		S_P1, S_P2, S_WP, S_FIN
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q, fin_go;

	assign fin_go = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) begin cmd.load = 1'b1; state_d = S_PX; end
			S_PX:   begin cmd.mop = hpp_pkg::MOP_PXPX; cmd.aop = hpp_pkg::AOP_LOAD; state_d = S_PY; end
			S_PY:   begin cmd.mop = hpp_pkg::MOP_PYPY; cmd.aop = hpp_pkg::AOP_ADD; state_d = S_PZ; end
			S_PZ:   begin cmd.mop = hpp_pkg::MOP_PZPZ; cmd.aop = hpp_pkg::AOP_ADD; state_d = S_W0; end
			S_W0:   state_d = S_SQ;
			S_SQ:   begin cmd.sq_go = 1'b1; state_d = S_TX; end
			S_TX:   begin cmd.mop = hpp_pkg::MOP_TXTX; cmd.aop = hpp_pkg::AOP_LOAD; state_d = S_TY; end
			S_TY:   begin cmd.mop = hpp_pkg::MOP_TYTY; cmd.aop = hpp_pkg::AOP_ADD; state_d = S_W1; end
			S_W1:   state_d = S_TGT;
			S_TGT:  begin cmd.st = hpp_pkg::ST_TGT; state_d = S_TSFS; end
			S_TSFS: begin cmd.mop = hpp_pkg::MOP_TSFS; cmd.aop = hpp_pkg::AOP_LOAD; state_d = S_W2; end
			S_W2:   state_d = S_NUM;
			S_NUM:  begin cmd.mop = hpp_pkg::MOP_NUM; cmd.aop = hpp_pkg::AOP_LOAD; state_d = S_W3; end
			S_W3:   state_d = S_SQW;
			S_SQW:  if (!sts.sq_busy) state_d = S_D8;
			S_D8:   begin cmd.div_go = 1'b1; state_d = S_D8W; end
			S_D8W:  if (!sts.div_busy) state_d = S_S8;
			S_S8:   begin cmd.st = hpp_pkg::ST_S8; state_d = S_APX; end
			S_APX:  begin cmd.mop = hpp_pkg::MOP_APX; cmd.aop = hpp_pkg::AOP_LOAD; state_d = S_WX; end
			S_WX:   state_d = S_DX;
			S_DX:   begin cmd.div_go = 1'b1; cmd.div_rad = 1'b1; state_d = S_DXW; end
			S_DXW:  if (!sts.div_busy) state_d = S_STX;
			S_STX:  begin cmd.st = hpp_pkg::ST_RX; state_d = S_APY; end
			S_APY:  begin cmd.mop = hpp_pkg::MOP_APY; cmd.aop = hpp_pkg::AOP_LOAD; state_d = S_WY; end
			S_WY:   state_d = S_DY;
			S_DY:   begin cmd.div_go = 1'b1; cmd.div_rad = 1'b1; state_d = S_DYW; end
			S_DYW:  if (!sts.div_busy) state_d = S_STY;
			S_STY:  begin cmd.st = hpp_pkg::ST_RY; state_d = S_ROT; end
			S_ROT:  begin cmd.cor_go = 1'b1; state_d = S_ROTW; end
			S_ROTW: if (!sts.cor_busy) state_d = S_M1;
			S_M1:   begin cmd.mop = hpp_pkg::MOP_RYC; cmd.aop = hpp_pkg::AOP_LOAD; state_d = S_M2; end
			S_M2:   begin cmd.mop = hpp_pkg::MOP_RXS; cmd.aop = hpp_pkg::AOP_ADD; state_d = S_WPX; end
			S_WPX:  state_d = S_STPX;
			S_STPX: begin cmd.st = hpp_pkg::ST_X; state_d = S_M3; end
			S_M3:   begin cmd.mop = hpp_pkg::MOP_RXC; cmd.aop = hpp_pkg::AOP_LOAD; state_d = S_M4; end
			S_M4:   begin cmd.mop = hpp_pkg::MOP_RYS; cmd.aop = hpp_pkg::AOP_ADD; state_d = S_WPY; end
			S_WPY:  state_d = S_STPY;
			S_STPY: begin cmd.st = hpp_pkg::ST_Y; state_d = S_M5; end
			S_M5:   begin cmd.mop = hpp_pkg::MOP_XX; cmd.aop = hpp_pkg::AOP_LOAD; state_d = S_M6; end
			S_M6:   begin cmd.mop = hpp_pkg::MOP_YY; cmd.aop = hpp_pkg::AOP_ADD; state_d = S_WR; end
			S_WR:   state_d = S_CHK;
			S_CHK: begin
				cmd.adv = 1'b1;
				state_d = (sts.limit_next || sts.outside) ? S_VEC : S_ROT;
			end
			S_VEC:  begin cmd.cor_go = 1'b1; cmd.cor_vec = 1'b1; state_d = S_VECW; end
			S_VECW: if (!sts.cor_busy) state_d = S_P1;
			S_P1:   begin cmd.mop = hpp_pkg::MOP_PLO; cmd.aop = hpp_pkg::AOP_LOAD; state_d = S_P2; end
			S_P2:   begin cmd.mop = hpp_pkg::MOP_PHI; cmd.aop = hpp_pkg::AOP_ADD16; state_d = S_WP; end
			S_WP:   state_d = S_FIN;
			S_FIN:  if (fin_go) begin cmd.out_load = 1'b1; state_d = S_IDLE; end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_go) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

[rtl/helix_propagate_phi_at_radius.sv]
`timescale 1ns / 1ps
// The time from input transfer to result valid is set by the square root, the divider
// (three divisions) and the CORDIC loop that runs for each helix step.
// Throughput: one item at a time; next item accepted once the result is in the
// output register. Up to step_limit+1 steps, each with 16 CORDIC stages.
// Reset: arst_n clears control, loads register defaults 973/102/10000.
// ----------------------------------------------------------------------------
// helix_propagate_phi_at_radius
// Steps a muon transverse helix to a target radius and reports the momentum
// direction angle there.
// ----------------------------------------------------------------------------
module helix_propagate_phi_at_radius (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [19:0] ref_x,
	input  logic signed [19:0] ref_y,
	input  logic signed [23:0] mom_x,
	input  logic signed [23:0] mom_y,
	input  logic signed [23:0] mom_z,
	input  logic               charge_negative,
	input  logic signed [19:0] target_x,
	input  logic signed [19:0] target_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] phi,
	output logic               limit_hit
);

	hpp_pkg::cmd_t cmd;
	hpp_pkg::sts_t sts;

	hpp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	hpp_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_data        (cfg_data),
		.ref_x           (ref_x),
		.ref_y           (ref_y),
		.mom_x           (mom_x),
		.mom_y           (mom_y),
		.mom_z           (mom_z),
		.charge_negative (charge_negative),
		.target_x        (target_x),
		.target_y        (target_y),
		.phi             (phi),
		.limit_hit       (limit_hit)
	);

endmodule

[verif/hpp_track_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpp_track_checker
// Watches the config port and both channels of the helix propagation block.
// Each input transfer is run through an independent fixed-point model of the
// helix search; each output transfer is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module hpp_track_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [19:0] ref_x,
	input  logic signed [19:0] ref_y,
	input  logic signed [23:0] mom_x,
	input  logic signed [23:0] mom_y,
	input  logic signed [23:0] mom_z,
	input  logic               charge_negative,
	input  logic signed [19:0] target_x,
	input  logic signed [19:0] target_y,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] phi,
	input  logic               limit_hit,
	output int                 mismatches,
	output int                 tracks_pending
);

	typedef struct {
		logic signed [15:0] phi;
		logic               lim;
	} track_result_t;

	localparam longint unsigned M32 = 64'hFFFF_FFFF;

	track_result_t expected_tracks[$];
	logic [11:0] field_q;
	logic [15:0] tstep_q;
	logic [13:0] limit_q;

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint clamp_to(longint v, longint cap);
		return v > cap ? cap : (v < -cap ? -cap : v);
	endfunction

	function automatic void rotate_unit(longint unsigned ang, output longint c,
			output longint s);
		longint z, x, y, dx, dy;
		bit flip;
		z = (ang >= 64'h8000_0000) ? longint'(ang) - 64'sh1_0000_0000 : longint'(ang);
		flip = 0;
		x = 10188014;
		y = 0;
		if (z > 64'sd1073741824) begin
			z = z - 64'sd2147483648;
			flip = 1;
		end else if (z < -64'sd1073741824) begin
			z = z + 64'sd2147483648;
			flip = 1;
		end
		for (int i = 0; i < hpp_pkg::CORDIC_STAGES && i < hpp_pkg::TAB_LEN; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - longint'(hpp_pkg::ATAN_TURNS[i]);
			end else begin
				x = x + dx; y = y - dy; z = z + longint'(hpp_pkg::ATAN_TURNS[i]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint unsigned heading_turns(longint px, longint py);
		longint x, y, z, dx, dy;
		x = px * 65536;
		y = py * 65536;
		z = 0;
		if (x < 0) begin
			x = -x; y = -y; z = 64'sd2147483648;
		end
		for (int i = 0; i < hpp_pkg::CORDIC_STAGES && i < hpp_pkg::TAB_LEN; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (y < 0) begin
				x = x - dx; y = y + dy; z = z - longint'(hpp_pkg::ATAN_TURNS[i]);
			end else begin
				x = x + dx; y = y - dy; z = z + longint'(hpp_pkg::ATAN_TURNS[i]);
			end
		end
		return longint'(z) & M32;
	endfunction

	function automatic longint unsigned turn_after(longint unsigned n,
			longint unsigned s8, bit negq);
		longint unsigned t;
		t = ((n * s8) >> 8) & M32;
		if (negq) t = (64'd0 - t) & M32;
		return t;
	endfunction

	function automatic longint bend_radius(longint p, longint unsigned dv, bit negq);
		longint unsigned m;
		longint r;
		m = ((p < 0 ? -p : p) * 64'd32000 + (dv >> 1)) / dv;
		r = clamp_to(longint'(m), 64'sd68719476736);
		if ((p < 0) != negq) r = -r;
		return r;
	endfunction

	function automatic track_result_t predict_track();
		track_result_t res;
		longint rx, ry, px, py, pz, tx, ty, radx, rady, c, s, x, y, phis;
		longint unsigned fs, esq, e20, s8, n, tgt, mag, dir, ph;
		bit negq, in_cyl, lim;
		rx = ref_x; ry = ref_y; px = mom_x; py = mom_y; pz = mom_z;
		tx = target_x; ty = target_y;
		negq = charge_negative;
		fs = field_q ? field_q : 1;
		esq = px * px + py * py + pz * pz + 749206;
		e20 = int_sqrt(esq << 14);
		if (e20 == 0) e20 = 1;
		s8 = ((longint'(tstep_q) * fs * 64'd2459112) << 8) / e20;
		radx = bend_radius(px, 3 * fs, negq);
		rady = bend_radius(py, 3 * fs, negq);
		tgt = tx * tx + ty * ty;
		n = 0;
		lim = 0;
		forever begin
			rotate_unit(turn_after(n, s8, negq), c, s);
			x = rx + floor_shift(rady * (64'sd16777216 - c) + radx * s, 24);
			y = ry + floor_shift(radx * (c - 64'sd16777216) + rady * s, 24);
			x = clamp_to(x, 64'sd4194304);
			y = clamp_to(y, 64'sd4194304);
			in_cyl = longint'(x * x + y * y) < longint'(tgt);
			n++;
			if (n > limit_q) begin
				lim = 1;
				break;
			end
			if (!in_cyl) break;
		end
		if (px == 0 && py == 0) begin
			res.phi = 0;
		end else begin
			dir = heading_turns(px, py);
			ph = (dir - turn_after(n, s8, negq)) & M32;
			phis = (ph >= 64'h8000_0000) ? longint'(ph) - 64'sh1_0000_0000 : longint'(ph);
			mag = ((phis < 0 ? -phis : phis) * 64'd3373259426 + (64'd1 << 47)) >> 48;
			res.phi = 16'(phis < 0 ? -longint'(mag) : longint'(mag));
		end
		res.lim = lim;
		return res;
	endfunction

	task automatic report_mismatch(string what);
		$display("ERROR t=%0t: %s", $realtime, what);
		mismatches++;
	endtask

	initial mismatches = 0;
	assign tracks_pending = expected_tracks.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q <= hpp_pkg::FS_RST;
			tstep_q <= hpp_pkg::TS_RST;
			limit_q <= hpp_pkg::LIM_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				hpp_pkg::REG_FIELD: field_q <= cfg_data[11:0];
				hpp_pkg::REG_TSTEP: tstep_q <= cfg_data;
				hpp_pkg::REG_LIMIT: limit_q <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		track_result_t e;
		if (arst_n && in_valid && !in_stall)
			expected_tracks.push_back(predict_track());
		if (arst_n && out_valid && !out_stall) begin
			if (expected_tracks.size() == 0) begin
				report_mismatch("output transfer with nothing expected");
			end else begin
				e = expected_tracks.pop_front();
				if (phi !== e.phi)
					report_mismatch($sformatf("phi %0d, expected %0d", phi, e.phi));
				if (limit_hit !== e.lim)
					report_mismatch($sformatf("limit_hit %0b, expected %0b",
						limit_hit, e.lim));
			end
		end
	end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the helix propagation block: directed corner tracks, then random
// tracks over several field/step/limit settings and idle/stall mixes. The
// checker predicts every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT = 20000000;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_idx;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic signed [19:0] ref_x, ref_y, target_x, target_y;
	logic signed [23:0] mom_x, mom_y, mom_z;
	logic               charge_negative;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] phi;
	logic               limit_hit;
	int                 mismatches;
	int                 tracks_pending;
	int                 send_idle_pct;
	int                 stall_pct;
	int                 cycles;

	helix_propagate_phi_at_radius dut (.*);
	hpp_track_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// cfg_we drops again after each write, which keeps back-to-back writes apart
	task automatic write_reg(hpp_pkg::reg_idx_t idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracks_pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_track(int rx, int ry, int px, int py, int pz, bit q,
			int tx, int ty);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		ref_x <= 20'(rx); ref_y <= 20'(ry);
		mom_x <= 24'(px); mom_y <= 24'(py); mom_z <= 24'(pz);
		charge_negative <= q;
		target_x <= 20'(tx); target_y <= 20'(ty);
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic int scaled_rand(int w);
		return $signed($urandom()) >>> (32 - $urandom_range(1, w));
	endfunction

	task automatic random_track();
		if ($urandom_range(99) < 80)
			send_track(scaled_rand(14), scaled_rand(14), scaled_rand(24),
				scaled_rand(24), scaled_rand(24), $urandom_range(1),
				scaled_rand(16), scaled_rand(16));
		else
			send_track($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom_range(1), $urandom(), $urandom());
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0; cfg_idx = 0; cfg_data = 0;
		in_valid = 0; out_stall = 0;
		ref_x = 0; ref_y = 0; mom_x = 0; mom_y = 0; mom_z = 0;
		charge_negative = 0; target_x = 0; target_y = 0;
		send_idle_pct = 0; stall_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings
		send_track(0, 0, 0, 0, 0, 0, 0, 0);
		send_track(0, 0, 0, 0, 8388607, 1, 100, 0);
		send_track(524287, 524287, 8388607, 8388607, 8388607, 0, 0, 0);
		send_track(-524288, -524288, -8388608, -8388608, -8388608, 1, 0, 0);
		send_track(1000, 0, 8192, 0, 0, 0, 500, 0);
		send_track(0, 1000, -8192, 0, 0, 1, 0, 500);
		send_track(-1000, 0, 0, 8192, 4096, 0, -500, 0);
		send_track(0, -1000, 0, -8192, -4096, 1, 0, -500);
		send_track(524287, -524288, 1, -1, 0, 0, -524288, 524287);
		send_track(2048, 2048, -8388608, 8388607, 0, 1, 0, 0);
		drain();
		write_reg(hpp_pkg::REG_LIMIT, 16'd0);
		send_track(0, 0, 8192, 8192, 0, 0, 20000, 20000);
		send_track(0, 0, 0, 0, 0, 1, -524288, -524288);
		drain();
		write_reg(hpp_pkg::REG_FIELD, 16'd0);
		write_reg(hpp_pkg::REG_TSTEP, 16'd0);
		write_reg(hpp_pkg::REG_LIMIT, 16'd16383);
		send_track(0, 0, 8192, -8192, 100, 1, 0, 0);
		send_track(5000, 0, 8388607, 0, 0, 0, 100, 100);
		drain();
		write_reg(hpp_pkg::REG_LIMIT, 16'd25);
		send_track(0, 0, 8192, 8192, 0, 0, 30000, 0);
		send_track(0, 0, -4096, 8192, 0, 1, 0, -30000);
		drain();
		write_reg(hpp_pkg::REG_FIELD, 16'd973);
		write_reg(hpp_pkg::REG_TSTEP, 16'd102);
		write_reg(hpp_pkg::REG_LIMIT, 16'd60);
		send_track(0, 0, 8192, 0, 0, 0, 10000, 0);
		send_track(0, 0, 8192, 0, 0, 1, 10000, 0);
		send_track(0, 0, 200, 300, 0, 0, 6000, 6000);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin write_reg(hpp_pkg::REG_FIELD, 16'd4095);
					write_reg(hpp_pkg::REG_TSTEP, 16'd65535);
					write_reg(hpp_pkg::REG_LIMIT, 16'd1); send_idle_pct = 0; stall_pct = 0; end
				1: begin write_reg(hpp_pkg::REG_FIELD, 16'd1);
					write_reg(hpp_pkg::REG_TSTEP, 16'd1);
					write_reg(hpp_pkg::REG_LIMIT, 16'd100); send_idle_pct = 50; stall_pct = 0; end
				2: begin write_reg(hpp_pkg::REG_FIELD, 16'd2048);
					write_reg(hpp_pkg::REG_TSTEP, 16'd500);
					write_reg(hpp_pkg::REG_LIMIT, 16'd30); send_idle_pct = 0; stall_pct = 50; end
				default: begin write_reg(hpp_pkg::REG_FIELD, 16'($urandom_range(1, 4095)));
					write_reg(hpp_pkg::REG_TSTEP, 16'($urandom_range(50, 2000)));
					write_reg(hpp_pkg::REG_LIMIT, 16'($urandom_range(8, 80)));
					send_idle_pct = 33; stall_pct = 33; end
			endcase
			for (int k = 0; k < 25; k++) begin
				random_track();
				if (k == 15 && ph == 3) drain();
			end
			drain();
			send_idle_pct = 0;
			stall_pct = 0;
		end
		write_reg(hpp_pkg::REG_FIELD, 16'd973);
		write_reg(hpp_pkg::REG_TSTEP, 16'd102);
		write_reg(hpp_pkg::REG_LIMIT, 16'd40);
		for (int k = 0; k < 20; k++) random_track();
		drain();
		repeat (300) @(posedge clk);
		if (mismatches == 0 && tracks_pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
